@@ src/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg: shared constants for the line rasterizer
// Port field widths, default tile size and queue sizing.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int PORT_COORD_W   = 6;
    localparam int COLOR_W        = 8;
    localparam int COORD_BITS_DEF = 6;
    localparam int QUEUE_DEPTH    = 2;

    // steep, down, maj0, min0, majd, inc (one bit wider), color
    function automatic int entry_width(input int coord_bits);
        return 4 * coord_bits + 3 + COLOR_W;
    endfunction

endpackage

@@ src/lr_line_if.sv @@
// ----------------------------------------------------------------------------
// lr_line_if: line request channel
// Two endpoints and a color byte, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lr_line_if;
    import lr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PORT_COORD_W-1:0] start_x;
    logic [PORT_COORD_W-1:0] start_y;
    logic [PORT_COORD_W-1:0] end_x;
    logic [PORT_COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]      color;

    modport source (output valid, start_x, start_y, end_x, end_y, color, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, color, output ready);

endinterface

@@ src/lr_pixel_if.sv @@
// ----------------------------------------------------------------------------
// lr_pixel_if: pixel write channel
// One pixel coordinate with color and end-of-line flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lr_pixel_if;
    import lr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PORT_COORD_W-1:0] pixel_x;
    logic [PORT_COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);

endinterface

@@ src/line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer: line walker for a square pixel tile
// Turns line requests into a stream of pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one line: start_x/start_y, end_x/end_y and a color byte.
//   pix carries one pixel write per item, with last set on the final pixel.
//   A line of major-axis length M gives M+1 pixels, from the lower to the
//   higher major coordinate, so 1 to 64 pixels on a 64x64 tile.
//   A request passes the queue, the walker registers and the output
//   register before its first pixel shows on pix.
//   Throughput: one pixel per cycle while pix accepts; a line holds the
//   walker for all its pixels, and the walker sets the request rate. The
//   next line loads in the same cycle as the final step of its predecessor.
//   A two-entry queue between the classifier and the walker takes requests
//   while a line is being drawn; req.ready drops only when it is full.
//   When pix stalls the pixel is held in the output register and the walker
//   waits; the queue keeps accepting until full.
//   Reset empties the queue and the output register, and drops pix.valid.
// ----------------------------------------------------------------------------
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lr_line_if.sink    req,
    lr_pixel_if.source pix
);
    import lr_pkg::*;

    localparam int ENTRY_W = entry_width(COORD_BITS);

    logic               push;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_data;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .req        (req),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    lr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .pix     (pix)
    );

endmodule

@@ src/lr_front.sv @@
// ----------------------------------------------------------------------------
// lr_front: line request classifier
// Picks the major axis, orders the endpoints and sets up the error step.
// ----------------------------------------------------------------------------
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    lr_line_if.sink                                       req,
    output logic                                          push,
    output logic [lr_pkg::entry_width(COORD_BITS)-1:0]    push_data,
    input  logic                                          push_ready
);
    import lr_pkg::*;

    typedef struct packed {
        logic                  steep;
        logic                  down;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] majd;
        logic [COORD_BITS:0]   inc;
        logic [COLOR_W-1:0]    color;
    } entry_t;

    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic [COORD_BITS-1:0] adx, ady;
    logic [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b, majd, mind;
    logic                  steep;
    logic                  swap;
    entry_t                entry;

    // only the low coordinate bits take part
    assign ax = req.start_x[COORD_BITS-1:0];
    assign ay = req.start_y[COORD_BITS-1:0];
    assign bx = req.end_x[COORD_BITS-1:0];
    assign by = req.end_y[COORD_BITS-1:0];

    always_comb
    begin
        adx   = (ax > bx) ? ax - bx : bx - ax;
        ady   = (ay > by) ? ay - by : by - ay;
        steep = ady > adx;
        if (steep)
        begin
            maj_a = ay;
            maj_b = by;
            min_a = ax;
            min_b = bx;
            majd  = ady;
            mind  = adx;
        end
        else
        begin
            maj_a = ax;
            maj_b = bx;
            min_a = ay;
            min_b = by;
            majd  = adx;
            mind  = ady;
        end
        // walk always goes up the major axis
        swap        = maj_a > maj_b;
        entry.steep = steep;
        entry.maj0  = swap ? maj_b : maj_a;
        entry.min0  = swap ? min_b : min_a;
        entry.down  = swap ? (min_a < min_b) : (min_b < min_a);
        entry.majd  = majd;
        entry.inc   = {1'b0, mind} + (COORD_BITS + 1)'(1);
        entry.color = req.color;
    end

    assign req.ready = push_ready;
    assign push      = req.valid;
    assign push_data = entry;

endmodule

@@ src/lr_queue.sv @@
// ----------------------------------------------------------------------------
// lr_queue: small request queue
// Register-based FIFO between classifier and walker.
// ----------------------------------------------------------------------------
module lr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/lr_back.sv @@
// ----------------------------------------------------------------------------
// lr_back: line walker
// Steps the major axis one pixel per unstalled cycle into a registered output.
// ----------------------------------------------------------------------------
module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  logic [lr_pkg::entry_width(COORD_BITS)-1:0] q_data,
    lr_pixel_if.source                                 pix
);
    import lr_pkg::*;

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic               steep;
        logic               down;
        logic [C-1:0]       maj0;
        logic [C-1:0]       min0;
        logic [C-1:0]       majd;
        logic [C:0]         inc;
        logic [COLOR_W-1:0] color;
    } entry_t;

    entry_t             entry;
    logic               active_reg, active_next;
    logic               steep_reg, steep_next;
    logic               down_reg, down_next;
    logic [C-1:0]       mj_reg, mj_next;
    logic [C-1:0]       mn_reg, mn_next;
    logic [C-1:0]       cnt_reg, cnt_next;
    logic [C:0]         inc_reg, inc_next;
    logic [C:0]         thr_reg, thr_next;
    logic [C:0]         err_reg, err_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               out_valid_reg, out_valid_next;
    logic [C-1:0]       out_x_reg, out_x_next;
    logic [C-1:0]       out_y_reg, out_y_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_last_reg, out_last_next;
    logic               advance;
    logic               line_end;
    logic [C+1:0]       err_sum;
    logic               wrap;

    assign entry    = entry_t'(q_data);
    assign advance  = active_reg && (!out_valid_reg || pix.ready);
    assign line_end = cnt_reg == '0;
    assign q_pop    = q_valid && (!active_reg || (advance && line_end));
    assign err_sum  = {1'b0, err_reg} + {1'b0, inc_reg};
    assign wrap     = err_sum >= {1'b0, thr_reg};

    always_comb
    begin
        active_next    = active_reg;
        steep_next     = steep_reg;
        down_next      = down_reg;
        mj_next        = mj_reg;
        mn_next        = mn_reg;
        cnt_next       = cnt_reg;
        inc_next       = inc_reg;
        thr_next       = thr_reg;
        err_next       = err_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !pix.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_x_next     = steep_reg ? mn_reg : mj_reg;
            out_y_next     = steep_reg ? mj_reg : mn_reg;
            out_color_next = color_reg;
            out_last_next  = line_end;
            mj_next        = mj_reg + 1'b1;
            cnt_next       = cnt_reg - 1'b1;
            if (wrap)
            begin
                err_next = (C + 1)'(err_sum - {1'b0, thr_reg});
                mn_next  = down_reg ? mn_reg - 1'b1 : mn_reg + 1'b1;
            end
            else
            begin
                err_next = (C + 1)'(err_sum);
            end
            if (line_end)
            begin
                active_next = 1'b0;
            end
        end

        // a new line can load in the cycle its predecessor ends
        if (q_pop)
        begin
            active_next = 1'b1;
            steep_next  = entry.steep;
            down_next   = entry.down;
            mj_next     = entry.maj0;
            mn_next     = entry.min0;
            cnt_next    = entry.majd;
            inc_next    = entry.inc;
            thr_next    = {1'b0, entry.majd} + (C + 1)'(1);
            err_next    = entry.inc >> 1;
            color_next  = entry.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg     <= steep_next;
        down_reg      <= down_next;
        mj_reg        <= mj_next;
        mn_reg        <= mn_next;
        cnt_reg       <= cnt_next;
        inc_reg       <= inc_next;
        thr_reg       <= thr_next;
        err_reg       <= err_next;
        color_reg     <= color_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = PORT_COORD_W'(out_x_reg);
    assign pix.pixel_y     = PORT_COORD_W'(out_y_reg);
    assign pix.pixel_color = out_color_reg;
    assign pix.last        = out_last_reg;

`ifndef NO_ASSERTIONS
    // error term stays below the threshold while walking
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> err_reg < thr_reg)
        else $error("error term out of range");

    // the final step of a line emits a pixel flagged last
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        advance && line_end |=> out_valid_reg && out_last_reg)
        else $error("last flag missing on final pixel");

    // inside a line the major coordinate steps by one
    a_major_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !line_end |=> mj_reg == C'($past(mj_reg) + 1'b1))
        else $error("major axis did not step");
`endif

endmodule
